@@ design/mcal_pkg.sv @@
package mcal_pkg;

	// Fixed field widths of the sample path.
	localparam int RAW_W    = 16;
	localparam int OFF_W    = 20;
	localparam int OFF_BITS = 3 * OFF_W;
	localparam int DIFF_W   = OFF_W + 1;
	localparam int OUT_W    = 24;
	localparam int NUM_AXES = 3;

	// Default coefficient format, signed Q2.14.
	localparam int COEF_WIDTH_DEF     = 16;
	localparam int COEF_FRAC_BITS_DEF = 14;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_HARD_IRON = 2'd0,
		REG_ROW_X     = 2'd1,
		REG_ROW_Y     = 2'd2,
		REG_ROW_Z     = 2'd3
	} cfg_reg_t;

endpackage

@@ design/magnetometer_sample_calibrate_core.sv @@
// Magnetometer sample calibration. Each input beat is one six-byte frame
// (big-endian, axes in X, Z, Y order). The output beat carries the three raw
// signed axes and the three calibrated axes: (raw * 16 - hard-iron offset)
// multiplied by the 3x3 soft-iron matrix, floored by COEF_FRAC_BITS and
// saturated to signed 24 bits with 4 fraction bits. The datapath is a
// four-stage pipeline (offset subtract, nine parallel multipliers, row sums,
// shift and saturate), and one frame is accepted every cycle while out_stall
// is low; a stalled stage absorbs bubbles ahead of it. Configuration
// registers take effect for frames entering after the write and must only be
// written while the pipeline is empty.
module magnetometer_sample_calibrate_core #(
	parameter int COEF_WIDTH     = mcal_pkg::COEF_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = mcal_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	// Configuration write port.
	input  logic                           wr_en,
	input  mcal_pkg::cfg_reg_t             wr_index,
	input  logic [((3 * COEF_WIDTH > mcal_pkg::OFF_BITS) ?
		3 * COEF_WIDTH : mcal_pkg::OFF_BITS) - 1:0] wr_data,

	// Frame input channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     x_high_byte,
	input  logic [7:0]                     x_low_byte,
	input  logic [7:0]                     z_high_byte,
	input  logic [7:0]                     z_low_byte,
	input  logic [7:0]                     y_high_byte,
	input  logic [7:0]                     y_low_byte,

	// Result output channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [mcal_pkg::RAW_W-1:0] raw_x,
	output logic signed [mcal_pkg::RAW_W-1:0] raw_y,
	output logic signed [mcal_pkg::RAW_W-1:0] raw_z,
	output logic signed [mcal_pkg::OUT_W-1:0] calibrated_x,
	output logic signed [mcal_pkg::OUT_W-1:0] calibrated_y,
	output logic signed [mcal_pkg::OUT_W-1:0] calibrated_z
);

	import mcal_pkg::*;

	localparam int ROW_BITS = 3 * COEF_WIDTH;
	localparam int PROD_W   = DIFF_W + COEF_WIDTH;
	localparam int SUM_W    = PROD_W + 2;
	localparam logic [ROW_BITS-1:0] COEF_ONE = ROW_BITS'(1) << COEF_FRAC_BITS;

	// Configuration registers.
	logic [OFF_BITS-1:0] off_q;
	logic [ROW_BITS-1:0] row_q [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			for (int r = 0; r < NUM_AXES; r++) begin
				row_q[r] <= COEF_ONE << (r * COEF_WIDTH);
			end
		end else if (wr_en) begin
			case (wr_index)
				REG_HARD_IRON: off_q    <= wr_data[OFF_BITS-1:0];
				REG_ROW_X:     row_q[0] <= wr_data[ROW_BITS-1:0];
				REG_ROW_Y:     row_q[1] <= wr_data[ROW_BITS-1:0];
				REG_ROW_Z:     row_q[2] <= wr_data[ROW_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Stage valid bits and per-stage advance enables. A stage moves when it
	// is empty or when the stage after it moves.
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !v_s4 || !out_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: assemble raw axes and subtract the hard-iron offsets.
	logic signed [RAW_W-1:0]  raw_in [NUM_AXES];
	logic signed [OFF_W-1:0]  off_c  [NUM_AXES];
	logic signed [RAW_W-1:0]  raw_s1 [NUM_AXES];
	logic signed [DIFF_W-1:0] diff_s1 [NUM_AXES];

	assign raw_in[0] = {x_high_byte, x_low_byte};
	assign raw_in[1] = {y_high_byte, y_low_byte};
	assign raw_in[2] = {z_high_byte, z_low_byte};

	always_comb begin
		for (int c = 0; c < NUM_AXES; c++) begin
			off_c[c] = off_q[c * OFF_W +: OFF_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int c = 0; c < NUM_AXES; c++) begin
				raw_s1[c]  <= raw_in[c];
				diff_s1[c] <= DIFF_W'($signed({raw_in[c], 4'b0000})) - DIFF_W'(off_c[c]);
			end
		end
	end

	// Stage 2: nine coefficient products.
	logic signed [COEF_WIDTH-1:0] coef [NUM_AXES][NUM_AXES];
	logic signed [PROD_W-1:0]     prod_s2 [NUM_AXES][NUM_AXES];
	logic signed [RAW_W-1:0]      raw_s2 [NUM_AXES];

	always_comb begin
		for (int r = 0; r < NUM_AXES; r++) begin
			for (int c = 0; c < NUM_AXES; c++) begin
				coef[r][c] = row_q[r][c * COEF_WIDTH +: COEF_WIDTH];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			raw_s2 <= raw_s1;
			for (int r = 0; r < NUM_AXES; r++) begin
				for (int c = 0; c < NUM_AXES; c++) begin
					prod_s2[r][c] <= PROD_W'(diff_s1[c]) * PROD_W'(coef[r][c]);
				end
			end
		end
	end

	// Stage 3: exact row sums.
	logic signed [SUM_W-1:0] sum_s3 [NUM_AXES];
	logic signed [RAW_W-1:0] raw_s3 [NUM_AXES];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			raw_s3 <= raw_s2;
			for (int r = 0; r < NUM_AXES; r++) begin
				sum_s3[r] <= SUM_W'(prod_s2[r][0]) + SUM_W'(prod_s2[r][1])
					+ SUM_W'(prod_s2[r][2]);
			end
		end
	end

	// Stage 4: floor shift (arithmetic right shift) and saturation.
	logic signed [SUM_W-1:0]     shifted [NUM_AXES];
	logic [SUM_W-OUT_W:0]        upper   [NUM_AXES];
	logic signed [OUT_W-1:0]     sat     [NUM_AXES];
	logic signed [OUT_W-1:0]     cal_s4  [NUM_AXES];
	logic signed [RAW_W-1:0]     raw_s4  [NUM_AXES];

	always_comb begin
		for (int r = 0; r < NUM_AXES; r++) begin
			shifted[r] = sum_s3[r] >>> COEF_FRAC_BITS;
			upper[r]   = shifted[r][SUM_W-1:OUT_W-1];
			if ((&upper[r]) || !(|upper[r])) begin
				sat[r] = shifted[r][OUT_W-1:0];
			end else if (shifted[r][SUM_W-1]) begin
				sat[r] = {1'b1, {(OUT_W-1){1'b0}}};
			end else begin
				sat[r] = {1'b0, {(OUT_W-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			raw_s4 <= raw_s3;
			cal_s4 <= sat;
		end
	end

	assign out_valid    = v_s4;
	assign raw_x        = raw_s4[0];
	assign raw_y        = raw_s4[1];
	assign raw_z        = raw_s4[2];
	assign calibrated_x = cal_s4[0];
	assign calibrated_y = cal_s4[1];
	assign calibrated_z = cal_s4[2];

	// Input is held off only when every stage holds a beat.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled while a pipeline stage is empty");

	// An accepted frame reaches the output when out_stall stays low while it passes through the pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
		|=> out_valid)
		else $error("accepted frame did not reach the output in four cycles");

	// A held row-sum stage keeps its beat and data.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en_s3) |=> (v_s3 && $stable(sum_s3[0]) && $stable(sum_s3[1])
			&& $stable(sum_s3[2])))
		else $error("stalled row-sum stage changed");

endmodule
